// ----- src/lsfe_pkg.sv -----
// shared types and constants for the lin slave frame engine
`default_nettype none
package lsfe_pkg;
  localparam logic [7:0] SYNC_BYTE = 8'h55;
  localparam logic [7:0] SID_STATE = 8'hB8;
  localparam logic [7:0] SID_ERROR = 8'hB2;
  localparam logic [5:0] ID_SETPT = 6'h20;
  localparam logic [5:0] ID_TEMPS = 6'h21;
  localparam logic [5:0] ID_STAT = 6'h22;
  localparam logic [5:0] ID_DREQ = 6'h3C;
  localparam logic [5:0] ID_DRSP = 6'h3D;
  localparam logic [5:0] ID_MISC = 6'h16;
  localparam int unsigned QDEPTH = 2;

  typedef enum logic [2:0] {
    CFG_ROOM = 3'd0, CFG_WATER = 3'd1, CFG_BURNER = 3'd2,
    CFG_ECLASS = 3'd3, CFG_ECODE = 3'd4, CFG_ESHORT = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    EV_NONE = 3'd0, EV_HEADER = 3'd1, EV_FRAME = 3'd2, EV_BADSUM = 3'd3, EV_SENT = 3'd4
  } event_t;

  typedef enum logic [1:0] {PH_HUNT = 2'd0, PH_PID = 2'd1, PH_DATA = 2'd2} phase_t;
  typedef enum logic [1:0] {SVC_NONE = 2'd0, SVC_STATE = 2'd1, SVC_ERROR = 2'd2} svc_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       timeout;
  } in_item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic [2:0]  event_res;
    logic [15:0] room_setpoint;
    logic [7:0]  water_setpoint;
    logic [7:0]  heater_modes;
    logic [1:0]  requested_state;
    logic [1:0]  current_state;
  } out_item_t;

  // classified job handed from front to back
  typedef struct packed {
    logic        send;
    logic [2:0]  event_res;
    logic [7:0]  pid;
    logic [63:0] data;   // byte i at [8i+7:8i]
    logic        classic; // checksum over data only, no pid seed
    logic [15:0] room_setpoint;
    logic [7:0]  water_setpoint;
    logic [7:0]  heater_modes;
    logic [1:0]  requested_state;
    logic [1:0]  current_state;
  } job_t;

  function automatic logic [7:0] add_carry(input logic [7:0] s, input logic [7:0] b);
    logic [8:0] t;
    t = {1'b0, s} + {1'b0, b};
    return t[8] ? (t[7:0] + 8'd1) : t[7:0];
  endfunction

  function automatic logic parity_ok(input logic [7:0] p);
    logic p0, p1;
    p0 = p[0] ^ p[1] ^ p[2] ^ p[4];
    p1 = ~(p[1] ^ p[3] ^ p[4] ^ p[5]);
    return (p[6] == p0) && (p[7] == p1);
  endfunction

  function automatic logic [3:0] data_len(input logic [5:0] id);
    logic [3:0] n;
    unique case (id)
      ID_SETPT, ID_TEMPS, ID_STAT, ID_DREQ, ID_DRSP, ID_MISC: n = 4'd8;
      6'h02, 6'h03, 6'h04, 6'h05, 6'h06, 6'h07: n = 4'd2;
      default: n = 4'd0;
    endcase
    return n;
  endfunction
endpackage
`default_nettype wire

// ----- src/lin_slave_frame_engine_top.sv -----
// top level of the lin slave frame engine
// a request taken by the parser is written into the job queue and reaches the output from the queue head
// the parser takes one request per cycle while the job queue is not full; a response pid yields 12 results
// the two-entry job queue lets the parser take bytes while a response drains
// reset (rst, synchronous, active high) empties the queue and restores all registers
// except the frame data store and the queue slots, which hold nothing valid until written
`default_nettype none
module lin_slave_frame_engine_top #(
  parameter int unsigned QUEUE_DEPTH = lsfe_pkg::QDEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire lsfe_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output lsfe_pkg::out_item_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic [11:0]         cfg_index,
  input  wire logic [11:0]         cfg_data
);
  import lsfe_pkg::*;

  // front to queue
  logic job_valid, q_full, q_avail, q_pop;
  job_t job_in, job_head;

  lsfe_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_data,
    .cfg_we, .cfg_index_w(cfg_index), .cfg_data_w(cfg_data),
    .job_valid, .job_full(q_full), .job(job_in)
  );

  // decouples parsing from response serialization
  lsfe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst, .push(job_valid), .push_job(job_in), .full(q_full),
    .avail(q_avail), .pop(q_pop), .head(job_head)
  );

  // response bytes and checksum go out one per cycle while out_stall is low
  lsfe_back u_back (
    .clk, .rst, .job_avail(q_avail), .job(job_head), .job_pop(q_pop),
    .out_valid, .out_stall, .out_data
  );

  // stall follows queue fill
  a_stall_full: assert property (@(posedge clk) disable iff (rst) in_stall == q_full)
    else $error("stall does not match queue full");
  // only response results carry a transmit byte
  a_tx_event: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.tx_valid == (out_data.event_res == EV_SENT)))
    else $error("tx_valid and event disagree");
  // a silent result is always the last one
  a_single: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.tx_valid) |-> out_data.tx_last)
    else $error("non-response result not marked last");
endmodule
`default_nettype wire

// ----- src/lsfe_front.sv -----
// front end: byte parser, state registers and job classification
`default_nettype none
module lsfe_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire lsfe_pkg::in_item_t in_data,
  input  wire logic             cfg_we,
  input  wire logic [11:0]      cfg_index_w,
  input  wire logic [11:0]      cfg_data_w,
  output logic                  job_valid,
  input  wire logic             job_full,
  output lsfe_pkg::job_t        job
);
  import lsfe_pkg::*;

  logic [11:0] room_temp, water_temp;
  logic        burner;
  logic [7:0]  err_class, err_code, err_short;
  phase_t      phase, phase_next;
  logic [7:0]  frame_pid, frame_pid_next, running_sum, running_sum_next;
  logic [3:0]  data_count, data_count_next;
  logic [7:0]  frame_data [8];
  logic [15:0] room_sp, room_sp_next;
  logic [7:0]  water_sp, water_sp_next, modes, modes_next;
  svc_t        pend_svc, pend_svc_next;
  logic [1:0]  pend_state, pend_state_next, req_state, req_state_next;
  logic [1:0]  cur_state, cur_state_next;
  logic        wr_data;
  logic [7:0]  d [8];
  logic        send;
  logic [2:0]  ev;
  logic [5:0]  id, fid;
  logic [7:0]  b;
  logic        acc;

  assign in_stall = job_full;
  assign acc = in_valid && !job_full;
  assign b = in_data.rx_byte;
  assign id = b[5:0];
  assign fid = frame_pid[5:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      room_temp <= 12'd2945; water_temp <= 12'd3210; burner <= 1'b0;
      err_class <= '0; err_code <= '0; err_short <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index_w[2:0]))
        CFG_ROOM:   if (cfg_index_w[11:3] == '0) room_temp <= cfg_data_w;
        CFG_WATER:  if (cfg_index_w[11:3] == '0) water_temp <= cfg_data_w;
        CFG_BURNER: if (cfg_index_w[11:3] == '0) burner <= cfg_data_w[0];
        CFG_ECLASS: if (cfg_index_w[11:3] == '0) err_class <= cfg_data_w[7:0];
        CFG_ECODE:  if (cfg_index_w[11:3] == '0) err_code <= cfg_data_w[7:0];
        CFG_ESHORT: if (cfg_index_w[11:3] == '0) err_short <= cfg_data_w[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next = phase; frame_pid_next = frame_pid; data_count_next = data_count;
    running_sum_next = running_sum; room_sp_next = room_sp; water_sp_next = water_sp;
    modes_next = modes; pend_svc_next = pend_svc; pend_state_next = pend_state;
    req_state_next = req_state; cur_state_next = cur_state;
    wr_data = 1'b0; send = 1'b0; ev = EV_NONE;
    for (int i = 0; i < 8; i++) d[i] = 8'h00;
    if (in_data.timeout) begin
      phase_next = PH_HUNT; data_count_next = '0; running_sum_next = '0;
    end else if (phase == PH_PID) begin
      phase_next = PH_HUNT;
      if (parity_ok(b) && data_len(id) != 4'd0) begin
        frame_pid_next = b;
        if (id == ID_TEMPS) begin
          d[0] = room_temp[7:0];
          d[1] = {water_temp[3:0], room_temp[11:8]};
          d[2] = water_temp[11:4];
          d[3] = SID_STATE;
          send = 1'b1;
        end else if (id == ID_STAT) begin
          d[0] = 8'h81;
          d[1] = burner ? 8'h40 : 8'hD0;
          d[2] = burner ? 8'd48 : 8'h10;
          send = 1'b1;
        end else if (id == ID_DRSP) begin
          if (pend_svc == SVC_STATE) begin
            d[0] = 8'h01; d[1] = 8'h06; d[2] = 8'hF8;
            d[3] = {6'd0, pend_state}; d[4] = {6'd0, cur_state};
            cur_state_next = pend_state; send = 1'b1;
          end else if (pend_svc == SVC_ERROR) begin
            d[0] = 8'h7F; d[1] = 8'h06; d[2] = 8'hF2;
            d[4] = err_class; d[5] = err_code; d[6] = err_short;
            send = 1'b1;
          end
          if (send) pend_svc_next = SVC_NONE;
          else ev = EV_HEADER;
        end else begin
          phase_next = PH_DATA; data_count_next = '0;
          running_sum_next = (id == ID_DREQ) ? 8'h00 : b;
          ev = EV_HEADER;
        end
      end
    end else if (phase == PH_DATA) begin
      if (data_count < data_len(fid)) begin
        wr_data = 1'b1;
        running_sum_next = add_carry(running_sum, b);
        data_count_next = data_count + 4'd1;
      end else begin
        if (b == ~running_sum) begin
          ev = EV_FRAME;
          if (fid == ID_SETPT) begin
            room_sp_next = {frame_data[1], frame_data[0]};
            water_sp_next = frame_data[2];
            modes_next = frame_data[5];
          end else if (fid == ID_DREQ) begin
            if (frame_data[2] == SID_STATE) begin
              pend_svc_next = SVC_STATE;
              pend_state_next = (frame_data[5] != 8'h00) ? 2'd2 : 2'd1;
              req_state_next = pend_state_next;
            end else if (frame_data[2] == SID_ERROR) begin
              pend_svc_next = SVC_ERROR;
            end
          end
        end else begin
          ev = EV_BADSUM;
        end
        phase_next = PH_HUNT; data_count_next = '0; running_sum_next = '0;
      end
    end else begin
      phase_next = (b == SYNC_BYTE) ? PH_PID : PH_HUNT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT; frame_pid <= '0; data_count <= '0; running_sum <= '0;
      room_sp <= 16'd43690; water_sp <= 8'd170; modes <= '0;
      pend_svc <= SVC_NONE; pend_state <= 2'd1; req_state <= 2'd1; cur_state <= 2'd1;
    end else if (acc) begin
      phase <= phase_next; frame_pid <= frame_pid_next; data_count <= data_count_next;
      running_sum <= running_sum_next; room_sp <= room_sp_next; water_sp <= water_sp_next;
      modes <= modes_next; pend_svc <= pend_svc_next; pend_state <= pend_state_next;
      req_state <= req_state_next; cur_state <= cur_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && wr_data) frame_data[data_count[2:0]] <= b;
  end

  always_comb begin
    job_valid = acc;
    job.send = send;
    job.event_res = send ? EV_SENT : ev;
    job.pid = b;
    job.data = {d[7], d[6], d[5], d[4], d[3], d[2], d[1], d[0]};
    // diagnostic response uses the classic checksum
    job.classic = (id == ID_DRSP);
    job.room_setpoint = room_sp_next;
    job.water_setpoint = water_sp_next;
    job.heater_modes = modes_next;
    job.requested_state = req_state_next;
    job.current_state = cur_state_next;
  end
endmodule
`default_nettype wire

// ----- src/lsfe_queue.sv -----
// small fifo of classified jobs between front and back
`default_nettype none
module lsfe_queue #(
  parameter int unsigned DEPTH = lsfe_pkg::QDEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire lsfe_pkg::job_t push_job,
  output logic               full,
  output logic               avail,
  input  wire logic          pop,
  output lsfe_pkg::job_t     head
);
  import lsfe_pkg::*;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  job_t slots [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   cnt;

  assign full = (cnt == (AW+1)'(DEPTH));
  assign avail = (cnt != '0);
  assign head = slots[rp];

  always_ff @(posedge clk) begin
    if (push) slots[wp] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      if (pop) rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

// ----- src/lsfe_back.sv -----
// back end: serializes each job into one or twelve result requests
`default_nettype none
module lsfe_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           job_avail,
  input  wire lsfe_pkg::job_t job,
  output logic                job_pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output lsfe_pkg::out_item_t out_data
);
  import lsfe_pkg::*;

  logic [3:0] idx;
  logic       last;
  logic [7:0] byte_sel;
  logic       fire;
  logic [7:0] csum;

  assign fire = job_avail && !out_stall;
  assign last = !job.send || (idx == 4'd11);
  assign job_pop = fire && last;
  assign out_valid = job_avail;

  always_comb begin
    unique case (idx)
      4'd0: byte_sel = 8'h00;
      4'd1: byte_sel = SYNC_BYTE;
      4'd2: byte_sel = job.pid;
      4'd11: byte_sel = ~csum;
      default: byte_sel = job.data[8*(idx - 4'd3) +: 8];
    endcase
    out_data.tx_valid = job.send;
    out_data.tx_byte = job.send ? byte_sel : 8'h00;
    out_data.tx_last = last;
    out_data.event_res = job.event_res;
    out_data.room_setpoint = job.room_setpoint;
    out_data.water_setpoint = job.water_setpoint;
    out_data.heater_modes = job.heater_modes;
    out_data.requested_state = job.requested_state;
    out_data.current_state = job.current_state;
  end

  // checksum gathered one data byte per emitted result
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0; csum <= '0;
    end else if (fire) begin
      idx <= last ? 4'd0 : idx + 4'd1;
      if (idx == 4'd2) csum <= job.classic ? 8'h00 : job.pid;
      else csum <= add_carry(csum, byte_sel);
    end
  end
endmodule
`default_nettype wire
